FILE: rtl/spq_pkg.sv
// Package for the sorted priority queue: capacity, field widths, codes and types.
// Shared by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package spq_pkg;

	// Number of entries the queue can hold.
	localparam int CAPACITY = 64;

	// Width of the internal entry counter, wide enough to hold CAPACITY itself.
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Fixed widths of the transaction fields.
	localparam int KEY_W   = 32;
	localparam int COUNT_W = 7;
	localparam int ERR_W   = 2;

	// Operation codes.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Error codes.
	localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

	// Input transaction.
	typedef struct packed {
		logic                    opcode;
		logic signed [KEY_W-1:0] value;
	} spq_in_t;

	// Result transaction.
	typedef struct packed {
		logic signed [KEY_W-1:0] min_value;
		logic                    min_valid;
		logic [COUNT_W-1:0]      entry_count;
		logic [ERR_W-1:0]        error_code;
	} spq_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic             do_insert;
		logic             do_remove;
		logic [ERR_W-1:0] err_code;
	} spq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
	} spq_status_t;

endpackage

`default_nettype wire

FILE: rtl/sorted_priority_queue.sv
// Sorted priority queue top level: joins the controller and the datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// Usage: a min priority queue of up to CAPACITY signed 32-bit keys, kept in
// ascending order in a row of compare-and-shift cells. Each input transaction
// is either an insert of value or a remove of the smallest key; equal keys
// leave in arrival order. Every input transaction yields exactly one result
// transaction carrying the minimum after the operation, its valid flag, the
// entry count and an error code (full on a dropped insert, empty on a remove
// from an empty queue; either leaves the contents unchanged).
// Result: registered; it is valid in the cycle after the input is accepted.
// Throughput: one transaction per cycle unless a held result waits on a low
// out_ready, since the whole cell row compares against the key and shifts at once.
// Stall: the result stays in its output register until taken; a new input is
// still accepted in the cycle the receiver takes the held result, and is
// held off only while a result waits and out_ready is low.
// Reset: arst_n empties the queue and drops any pending result.
`default_nettype none

module sorted_priority_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire spq_pkg::spq_in_t in_data,
	output logic              out_valid,
	input  wire               out_ready,
	output spq_pkg::spq_out_t out_data
);
	import spq_pkg::*;

	spq_cmd_t    cmd;
	spq_status_t status;

	// Handshake and command decode.
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (in_data.opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Key cells, counter and result register.
	spq_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.key    (in_data.value),
		.status (status),
		.result (out_data)
	);

endmodule

`default_nettype wire

FILE: rtl/spq_datapath.sv
// Datapath of the sorted priority queue: the row of key cells, the entry counter
// and the result register. Depends on spq_pkg.
`default_nettype none

module spq_datapath (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire spq_pkg::spq_cmd_t     cmd,
	input  wire logic signed [31:0]    key,
	output spq_pkg::spq_status_t       status,
	output spq_pkg::spq_out_t          result
);
	import spq_pkg::*;

	logic signed [KEY_W-1:0] cell_q  [CAPACITY];
	logic signed [KEY_W-1:0] cell_nx [CAPACITY];
	logic [CAPACITY-1:0]     gt;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_nx;
	logic signed [KEY_W-1:0] min_nx;
	spq_out_t                result_q;

	// Each cell flags whether it lies past the fill level or holds a key strictly greater.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			gt[i] = (CNT_W'(i) >= count_q) || (cell_q[i] > key);
		end
	end

	// Per-cell next value: shift up and take the key on insert, shift down on remove.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [KEY_W-1:0] from_below;
		logic signed [KEY_W-1:0] from_above;
		logic                    gt_below;

		if (g == 0) begin : g_first
			assign from_below = key;
			assign gt_below   = 1'b0;
		end else begin : g_rest
			assign from_below = cell_q[g-1];
			assign gt_below   = gt[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign from_above = cell_q[g];
		end else begin : g_inner
			assign from_above = cell_q[g+1];
		end

		always_comb begin
			if (cmd.do_remove) begin
				cell_nx[g] = from_above;
			end else if (cmd.do_insert && gt[g]) begin
				cell_nx[g] = gt_below ? from_below : key;
			end else begin
				cell_nx[g] = cell_q[g];
			end
		end

		// Key storage holds no reset; only cells below the count are ever read.
		always_ff @(posedge clk) begin
			if (cmd.do_insert || cmd.do_remove) begin
				cell_q[g] <= cell_nx[g];
			end
		end
	end

	// Next entry count.
	always_comb begin
		if (cmd.do_insert) begin
			count_nx = count_q + CNT_W'(1);
		end else if (cmd.do_remove) begin
			count_nx = count_q - CNT_W'(1);
		end else begin
			count_nx = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nx;
		end
	end

	// The minimum after this transaction reads as zero when the queue ends up empty.
	assign min_nx = (count_nx != '0) ? cell_nx[0] : '0;

	// Result register, loaded once per accepted transaction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			result_q.min_value   <= min_nx;
			result_q.min_valid   <= (count_nx != '0);
			result_q.entry_count <= COUNT_W'(count_nx);
			result_q.error_code  <= cmd.err_code;
		end
	end

	assign result       = result_q;
	assign status.full  = (count_q == CNT_W'(CAPACITY));
	assign status.empty = (count_q == '0);

`ifndef SYNTHESIS
	// The fill level never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// An insert raises the count by exactly one.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_insert |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not raise the count by one");

	// A remove lowers the count by exactly one.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_remove |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("remove did not lower the count by one");

	// Insert and remove are never commanded together, nor outside a load.
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_insert || cmd.do_remove) |-> (cmd.load && !(cmd.do_insert && cmd.do_remove)))
		else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

FILE: rtl/spq_ctrl.sv
// Controller of the sorted priority queue: handshakes, output hold state and
// command decode with error checks. Depends on spq_pkg.
`default_nettype none

module spq_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire                   opcode,
	output logic                  out_valid,
	input  wire                   out_ready,
	input  wire spq_pkg::spq_status_t status,
	output spq_pkg::spq_cmd_t     cmd
);
	import spq_pkg::*;

	// Output state: no result waiting, or a result held for the receiver.
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_HOLD = 1'b1;

	logic state_q;
	logic accept;

	// A new transaction is taken whenever the result slot is free or being emptied.
	assign in_ready  = (state_q == ST_IDLE) || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == ST_HOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_ready && !accept) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Decode the operation and reject an insert when full or a remove when empty.
	always_comb begin
		cmd.load      = accept;
		cmd.do_insert = 1'b0;
		cmd.do_remove = 1'b0;
		cmd.err_code  = ERR_NONE;
		if (accept) begin
			if (opcode == OP_INSERT) begin
				if (status.full) begin
					cmd.err_code = ERR_FULL;
				end else begin
					cmd.do_insert = 1'b1;
				end
			end else begin
				if (status.empty) begin
					cmd.err_code = ERR_EMPTY;
				end else begin
					cmd.do_remove = 1'b1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	// Every accepted transaction leaves a result waiting in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted transaction produced no result");

	// A full error only arises from an insert into a full queue.
	a_full_err: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.err_code == ERR_FULL) |-> (accept && status.full && opcode == OP_INSERT))
		else $error("spurious full error");

	// An empty error only arises from a remove on an empty queue.
	a_empty_err: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.err_code == ERR_EMPTY) |-> (accept && status.empty && opcode == OP_REMOVE))
		else $error("spurious empty error");
`endif

endmodule

`default_nettype wire
